FILE: hw/rtl/sha1_pkg.sv
`default_nettype none

package sha1_pkg;

  localparam int BLOCK_BYTES  = 64;
  localparam int LEN_POS      = 56;
  localparam int ROUNDS       = 80;
  localparam int DIGEST_WORDS = 5;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // element 0 is H0
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  typedef logic [4:0][31:0] work_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_UPDATE,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic       shift;
    byte_sel_t  sel;
    logic [2:0] len_idx;
    logic       count_bits;
    logic       load_work;
    logic       round;
    logic [6:0] rnd;
    logic       update;
    logic       reinit;
    logic       out_valid;
    logic [2:0] widx;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sha1_in_if.sv
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       is_last;

  modport source (output valid, output data_byte, output byte_valid, output is_last,
                  input ready);
  modport sink (input valid, input data_byte, input byte_valid, input is_last,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sha1_out_if.sv
`default_nettype none

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sha1_round.sv
`default_nettype none

module sha1_round (
  input  var sha1_pkg::work_t work,
  input  var logic [31:0]     w,
  input  var logic [6:0]      rnd,
  output sha1_pkg::work_t     work_next
);
  import sha1_pkg::*;

  logic [31:0] a, b, c, d, e;
  logic [31:0] f;
  logic [31:0] k;

  assign a = work[0];
  assign b = work[1];
  assign c = work[2];
  assign d = work[3];
  assign e = work[4];

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  always_comb begin
    work_next[0] = {a[26:0], a[31:27]} + f + e + k + w;
    work_next[1] = a;
    work_next[2] = {b[1:0], b[31:2]};
    work_next[3] = c;
    work_next[4] = d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sha1_ctrl.sv
`default_nettype none

module sha1_ctrl (
  input  var logic        clk,
  input  var logic        rst,
  input  var logic        in_valid,
  input  var logic        byte_valid,
  input  var logic        is_last,
  input  var logic        out_ready,
  output logic            in_ready,
  output sha1_pkg::ctrl_t ctl
);
  import sha1_pkg::*;

  localparam logic [5:0] LAST_POS  = 6'(BLOCK_BYTES - 1);
  localparam logic [5:0] LEN_START = 6'(LEN_POS);
  localparam logic [6:0] LAST_RND  = 7'(ROUNDS - 1);
  localparam logic [2:0] LAST_WORD = 3'(DIGEST_WORDS - 1);

  state_t     state, state_next;
  logic [5:0] count;
  logic [6:0] rnd;
  logic [2:0] widx;
  logic       finishing;
  logic       mark_sent;
  logic       pad_extra;
  logic       len_done;
  logic       len_byte;

  assign in_ready = (state == S_IDLE) && !rst;
  assign len_byte = mark_sent && !pad_extra && (count >= LEN_START);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (byte_valid && count == LAST_POS) state_next = S_ROUND;
          else if (is_last) state_next = S_PAD;
        end
      end
      S_PAD: begin
        if (count == LAST_POS) state_next = S_ROUND;
      end
      S_ROUND: begin
        if (rnd == LAST_RND) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (!finishing) state_next = S_IDLE;
        else if (len_done) state_next = S_OUT;
        else state_next = S_PAD;
      end
      S_OUT: begin
        if (out_ready && widx == LAST_WORD) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.sel        = BSEL_DATA;
    ctl.len_idx    = count[2:0];
    ctl.rnd        = rnd;
    ctl.widx       = widx;
    case (state)
      S_IDLE: begin
        ctl.shift      = in_valid && byte_valid;
        ctl.count_bits = in_valid && byte_valid;
        ctl.load_work  = in_valid && byte_valid && (count == LAST_POS);
      end
      S_PAD: begin
        ctl.shift     = 1'b1;
        ctl.load_work = (count == LAST_POS);
        if (!mark_sent) ctl.sel = BSEL_MARK;
        else if (len_byte) ctl.sel = BSEL_LEN;
        else ctl.sel = BSEL_ZERO;
      end
      S_ROUND:  ctl.round  = 1'b1;
      S_UPDATE: ctl.update = 1'b1;
      S_OUT: begin
        ctl.out_valid = 1'b1;
        ctl.reinit    = out_ready && (widx == LAST_WORD);
      end
      default: ctl.sel = BSEL_DATA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rnd       <= '0;
      widx      <= '0;
      finishing <= 1'b0;
      mark_sent <= 1'b0;
      pad_extra <= 1'b0;
      len_done  <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.shift) count <= count + 6'd1;
      rnd <= (state == S_ROUND && rnd != LAST_RND) ? rnd + 7'd1 : 7'd0;
      if (state == S_IDLE && in_valid && is_last) finishing <= 1'b1;
      if (state == S_PAD) begin
        if (!mark_sent) begin
          mark_sent <= 1'b1;
          pad_extra <= (count >= LEN_START) && (count != LAST_POS);
        end else if (pad_extra && count == LAST_POS) begin
          pad_extra <= 1'b0;
        end
        if (len_byte && count == LAST_POS) len_done <= 1'b1;
      end
      if (state == S_OUT && out_ready) begin
        widx <= (widx == LAST_WORD) ? 3'd0 : widx + 3'd1;
      end
      if (ctl.reinit) begin
        finishing <= 1'b0;
        mark_sent <= 1'b0;
        pad_extra <= 1'b0;
        len_done  <= 1'b0;
        count     <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_full_block_compresses: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD && count == LAST_POS) |=> (state == S_ROUND && rnd == 7'd0))
    else $error("full padded block did not start compression");

  a_idle_after_plain_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && !finishing) |=> (state == S_IDLE))
    else $error("block update without last did not return to idle");

  a_output_block_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (count == 6'd0 && len_done && finishing))
    else $error("digest output before padding finished");

  a_round_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (state != S_ROUND) |-> (rnd == 7'd0))
    else $error("round counter running outside compression");

  a_no_accept_while_output: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && ctl.out_valid))
    else $error("input ready while digest pending");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/sha1_hash_engine.sv
// SHA-1 hash engine.
// Input channel msg carries one beat per message byte: data_byte is absorbed
// when byte_valid is set; is_last closes the message (a last beat with
// byte_valid low closes it without a byte). A beat with neither does nothing.
// Output channel digest returns five beats per message: the 160-bit digest as
// 32-bit words, H0 first, word_index 0..4, last_word set on the fifth beat.
// The 64th byte of a block starts the compression: 80 rounds at one round
// per cycle on a single round unit, then a fold into the chaining words.
// On a last beat that leaves p bytes pending, 64 - p padding bytes are
// shifted in at one per cycle and the block is compressed; with p of 56 or
// more an extra padded block follows, and a last byte that completes a
// block first has that block compressed on its own.
// msg.ready is low during reset, compression, padding and digest output.
// If the receiver stalls, the current digest word holds until taken; the
// engine re-initializes after the fifth beat and then takes new bytes.
// Reset (rst, synchronous) loads the initial chaining values and clears the
// length count; the engine is ready as soon as reset is released.
`default_nettype none

module sha1_hash_engine (
  input  var logic  clk,
  input  var logic  rst,
  sha1_in_if.sink   msg,
  sha1_out_if.source digest
);
  import sha1_pkg::*;

  ctrl_t            ctl;
  logic [511:0]     blk;
  work_t            work;
  work_t            work_next;
  logic [4:0][31:0] chain;
  logic [7:0][7:0]  bitlen;
  logic [7:0]       shift_byte;
  logic [31:0]      sched_mix;
  logic [31:0]      sched_new;
  logic [31:0]      w0;

  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (msg.valid),
    .byte_valid (msg.byte_valid),
    .is_last    (msg.is_last),
    .out_ready  (digest.ready),
    .in_ready   (msg.ready),
    .ctl        (ctl)
  );

  sha1_round u_round (
    .work      (work),
    .w         (w0),
    .rnd       (ctl.rnd),
    .work_next (work_next)
  );

  // window word i sits at blk[511-32i -: 32]
  assign w0        = blk[511:480];
  assign sched_mix = blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ w0;
  assign sched_new = {sched_mix[30:0], sched_mix[31]};

  always_comb begin
    case (ctl.sel)
      BSEL_DATA: shift_byte = msg.data_byte;
      BSEL_MARK: shift_byte = PAD_MARK;
      BSEL_ZERO: shift_byte = 8'h00;
      BSEL_LEN:  shift_byte = bitlen[3'd7 - ctl.len_idx];
      default:   shift_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) blk <= {blk[503:0], shift_byte};
    else if (ctl.round) blk <= {blk[479:0], sched_new};
  end

  always_ff @(posedge clk) begin
    if (ctl.load_work) work <= chain;
    else if (ctl.round) work <= work_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain  <= H_INIT;
      bitlen <= '0;
    end else begin
      if (ctl.update) begin
        for (int i = 0; i < DIGEST_WORDS; i++) chain[i] <= chain[i] + work[i];
      end
      if (ctl.count_bits) bitlen <= bitlen + 64'd8;
      if (ctl.reinit) begin
        chain  <= H_INIT;
        bitlen <= '0;
      end
    end
  end

  assign digest.valid       = ctl.out_valid;
  assign digest.digest_word = chain[ctl.widx];
  assign digest.word_index  = ctl.widx;
  assign digest.last_word   = (ctl.widx == 3'(DIGEST_WORDS - 1));

endmodule

`default_nettype wire
